// ===== sv/kms_pkg.sv =====
// Shared types, constants and the report code table of the keypad scanner.
package kms_pkg;

   localparam int ROW_COUNT = 8;
   localparam int COLUMN_COUNT_DEFAULT = 4;
   localparam int COLUMN_WIDTH = 2;
   localparam int DRIVE_WIDTH = 4;

   localparam logic [1:0] CSR_SHIFT_OVERRIDE = 2'd0;
   localparam logic [1:0] CSR_DEBOUNCE_TICKS = 2'd1;
   localparam logic [1:0] CSR_LONG_PRESS_TICKS = 2'd2;

   localparam logic [7:0] DEBOUNCE_RESET = 8'd10;
   localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;

   localparam logic [4:0] SC_BAND_SHIFT = 5'd9;
   localparam logic [4:0] SC_ENC_SHIFT = 5'd27;
   localparam logic [5:0] CODE_ENC5 = 6'd13;
   localparam logic [5:0] CODE_ENC5_SHIFTED = 6'd41;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_WAIT_PRESS = 3'd1;
   localparam logic [2:0] PH_PRESSED = 3'd2;
   localparam logic [2:0] PH_WAIT_RELEASE = 3'd3;
   localparam logic [2:0] PH_MULTI = 3'd4;
   localparam logic [2:0] PH_WAIT_MULTI_RELEASE = 3'd5;

   localparam logic [1:0] EV_PRESS = 2'd0;
   localparam logic [1:0] EV_RELEASE = 2'd1;
   localparam logic [1:0] EV_LONG = 2'd2;

   typedef struct packed {
      logic       many;
      logic [3:0] row;
   } row_class_type;

   function automatic logic [5:0] code_lookup(input logic [5:0] idx);
      logic [5:0] code;
      case (idx)
         6'd0: code = 6'd4;   6'd1: code = 6'd5;   6'd2: code = 6'd6;   6'd3: code = 6'd7;
         6'd4: code = 6'd1;   6'd5: code = 6'd2;   6'd6: code = 6'd3;   6'd7: code = 6'd0;
         6'd8: code = 6'd8;   6'd9: code = 6'd39;  6'd10: code = 6'd23; 6'd11: code = 6'd20;
         6'd12: code = 6'd17; 6'd13: code = 6'd14; 6'd14: code = 6'd0;  6'd15: code = 6'd0;
         6'd16: code = 6'd24; 6'd17: code = 6'd25; 6'd18: code = 6'd21; 6'd19: code = 6'd22;
         6'd20: code = 6'd18; 6'd21: code = 6'd19; 6'd22: code = 6'd15; 6'd23: code = 6'd16;
         6'd24: code = 6'd9;  6'd25: code = 6'd10; 6'd26: code = 6'd11; 6'd27: code = 6'd40;
         6'd28: code = 6'd12; 6'd29: code = 6'd13; 6'd30: code = 6'd0;  6'd31: code = 6'd0;
         6'd32: code = 6'd4;  6'd33: code = 6'd5;  6'd34: code = 6'd6;  6'd35: code = 6'd7;
         6'd36: code = 6'd1;  6'd37: code = 6'd2;  6'd38: code = 6'd3;  6'd39: code = 6'd0;
         6'd40: code = 6'd8;  6'd41: code = 6'd39; 6'd42: code = 6'd36; 6'd43: code = 6'd33;
         6'd44: code = 6'd30; 6'd45: code = 6'd27; 6'd46: code = 6'd0;  6'd47: code = 6'd0;
         6'd48: code = 6'd37; 6'd49: code = 6'd38; 6'd50: code = 6'd34; 6'd51: code = 6'd35;
         6'd52: code = 6'd31; 6'd53: code = 6'd32; 6'd54: code = 6'd28; 6'd55: code = 6'd29;
         6'd56: code = 6'd9;  6'd57: code = 6'd10; 6'd58: code = 6'd11; 6'd59: code = 6'd40;
         6'd60: code = 6'd12; 6'd61: code = 6'd13; 6'd62: code = 6'd0;  6'd63: code = 6'd0;
         default: code = 6'd0;
      endcase
      return code;
   endfunction

endpackage

// ===== sv/keypad_matrix_scan_debounce.sv =====
// Top level of the keypad matrix scanner with debounce.
// Each request is one scan tick carrying the active-low rows of the driven column; each
// request yields exactly one response with any press, release or long-press event, the
// column to drive next and the two shift flags. One request per clock is sustained while
// rsp_stall is low: the front end classifies rows into a two-entry queue and the back end
// runs the sequencer one queued tick per cycle into a response register, so a response is
// offered once its request has passed the queue and the response register. Settings may be
// written at any time the block is idle; csr_ready is always high.
module keypad_matrix_scan_debounce #(
   parameter int COLUMN_COUNT = kms_pkg::COLUMN_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_row_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_event_valid,
   output logic [1:0]  rsp_event_kind,
   output logic [5:0]  rsp_button_code,
   output logic [3:0]  rsp_column_drive,
   output logic        rsp_band_shift_on,
   output logic        rsp_encoder_shift_on,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic                   q_valid;
   logic                   q_pop;
   kms_pkg::row_class_type q_class;

   kms_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_row_bits (req_row_bits),
      .req_stall    (req_stall),
      .q_valid      (q_valid),
      .q_class      (q_class),
      .q_pop        (q_pop)
   );

   kms_back #(
      .COLUMN_COUNT (COLUMN_COUNT)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .q_valid              (q_valid),
      .q_class              (q_class),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_event_valid      (rsp_event_valid),
      .rsp_event_kind       (rsp_event_kind),
      .rsp_button_code      (rsp_button_code),
      .rsp_column_drive     (rsp_column_drive),
      .rsp_band_shift_on    (rsp_band_shift_on),
      .rsp_encoder_shift_on (rsp_encoder_shift_on)
   );

endmodule

// ===== sv/kms_front.sv =====
// Front end: accepts row samples, classifies them and queues the class.
module kms_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [7:0]             req_row_bits,
   output logic                   req_stall,
   output logic                   q_valid,
   output kms_pkg::row_class_type q_class,
   input  logic                   q_pop
);

   kms_pkg::row_class_type queue_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       push;
   logic       pop;
   kms_pkg::row_class_type new_class;

   always_comb begin
      new_class.many = 1'b0;
      new_class.row = 4'd0;
      for (int i = 0; i < kms_pkg::ROW_COUNT; i++) begin
         if (!req_row_bits[i]) begin
            if (!new_class.many && new_class.row == 4'd0) begin
               new_class.row = 4'(i + 1);
            end else begin
               new_class.many = 1'b1;
               new_class.row = 4'd0;
            end
         end
      end
   end

   assign req_stall = count_ff[1];
   assign push = req_valid && !req_stall;
   assign q_valid = count_ff != 2'd0;
   assign pop = q_pop && q_valid;
   assign q_class = queue_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_class;
      end
   end

endmodule

// ===== sv/kms_back.sv =====
// Back end: debounce sequencer, event lookup, settings and result register.
module kms_back #(
   parameter int COLUMN_COUNT = kms_pkg::COLUMN_COUNT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_data,
   input  logic                   q_valid,
   input  kms_pkg::row_class_type q_class,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_event_valid,
   output logic [1:0]             rsp_event_kind,
   output logic [5:0]             rsp_button_code,
   output logic [3:0]             rsp_column_drive,
   output logic                   rsp_band_shift_on,
   output logic                   rsp_encoder_shift_on
);

   localparam logic [kms_pkg::COLUMN_WIDTH-1:0] LAST_COLUMN =
      kms_pkg::COLUMN_WIDTH'(COLUMN_COUNT - 1);

   logic        shift_override_ff;
   logic [7:0]  debounce_ticks_ff;
   logic [15:0] long_press_ticks_ff;

   logic [2:0]  phase_ff, phase_in;
   logic [kms_pkg::COLUMN_WIDTH-1:0] column_ff, column_in;
   logic [3:0]  held_row_ff, held_row_in;
   logic [7:0]  wait_ff, wait_in;
   logic [15:0] hold_ff, hold_in;
   logic        band_ff, band_in;
   logic        enc_ff, enc_in;

   logic        out_valid_ff;
   logic        ev_valid_ff, ev_valid_in;
   logic [1:0]  ev_kind_ff, ev_kind_in;
   logic [5:0]  ev_code_ff, ev_code_in;
   logic [3:0]  drive_ff;
   logic        band_out_ff;
   logic        enc_out_ff;

   logic        step;
   logic        row_none;
   logic        row_held;
   logic        fire;
   logic [1:0]  fire_kind;
   logic [4:0]  scan;
   logic        use_upper;
   logic [5:0]  rom_code;
   logic [5:0]  code;

   assign csr_ready = 1'b1;
   assign q_pop = !out_valid_ff || !rsp_stall;
   assign step = q_valid && q_pop;

   assign row_none = !q_class.many && q_class.row == 4'd0;
   assign row_held = !q_class.many && q_class.row == held_row_ff;

   assign scan = 5'({column_ff, 3'b000}) + 5'(held_row_ff) - 5'd1;

   always_comb begin
      phase_in = phase_ff;
      column_in = column_ff;
      held_row_in = held_row_ff;
      wait_in = wait_ff;
      hold_in = hold_ff;
      fire = 1'b0;
      fire_kind = kms_pkg::EV_PRESS;
      if (wait_ff != 8'd0) begin
         wait_in = wait_ff - 8'd1;
      end else begin
         case (phase_ff)
            kms_pkg::PH_WAIT_PRESS: begin
               if (row_held) begin
                  phase_in = kms_pkg::PH_PRESSED;
                  fire = 1'b1;
                  fire_kind = kms_pkg::EV_PRESS;
                  hold_in = long_press_ticks_ff;
               end else begin
                  phase_in = kms_pkg::PH_MULTI;
                  wait_in = debounce_ticks_ff;
               end
            end
            kms_pkg::PH_PRESSED: begin
               if (row_none) begin
                  phase_in = kms_pkg::PH_WAIT_RELEASE;
                  wait_in = debounce_ticks_ff;
               end else if (!row_held) begin
                  phase_in = kms_pkg::PH_MULTI;
                  wait_in = debounce_ticks_ff;
                  fire = 1'b1;
                  fire_kind = kms_pkg::EV_RELEASE;
               end else if (hold_ff != 16'd0) begin
                  hold_in = hold_ff - 16'd1;
                  if (hold_ff == 16'd1) begin
                     fire = 1'b1;
                     fire_kind = kms_pkg::EV_LONG;
                  end
               end
            end
            kms_pkg::PH_WAIT_RELEASE: begin
               if (row_none) begin
                  phase_in = kms_pkg::PH_IDLE;
                  wait_in = debounce_ticks_ff;
                  fire = 1'b1;
                  fire_kind = kms_pkg::EV_RELEASE;
               end else if (!row_held) begin
                  phase_in = kms_pkg::PH_MULTI;
                  wait_in = debounce_ticks_ff;
               end
            end
            kms_pkg::PH_MULTI: begin
               if (row_none) begin
                  phase_in = kms_pkg::PH_WAIT_MULTI_RELEASE;
                  wait_in = debounce_ticks_ff;
               end
            end
            kms_pkg::PH_WAIT_MULTI_RELEASE: begin
               phase_in = row_none ? kms_pkg::PH_IDLE : kms_pkg::PH_MULTI;
               wait_in = debounce_ticks_ff;
            end
            default: begin
               if (row_none) begin
                  phase_in = kms_pkg::PH_IDLE;
                  column_in = (column_ff == LAST_COLUMN) ?
                     '0 : column_ff + kms_pkg::COLUMN_WIDTH'(1);
               end else if (q_class.many) begin
                  phase_in = kms_pkg::PH_MULTI;
                  wait_in = debounce_ticks_ff;
               end else begin
                  held_row_in = q_class.row;
                  phase_in = kms_pkg::PH_WAIT_PRESS;
                  wait_in = debounce_ticks_ff;
               end
            end
         endcase
      end
   end

   assign use_upper = !shift_override_ff && band_ff;
   assign rom_code = kms_pkg::code_lookup({use_upper, scan});
   assign code = (enc_ff && rom_code == kms_pkg::CODE_ENC5) ?
      kms_pkg::CODE_ENC5_SHIFTED : rom_code;

   always_comb begin
      band_in = band_ff;
      enc_in = enc_ff;
      ev_valid_in = 1'b0;
      ev_kind_in = kms_pkg::EV_PRESS;
      ev_code_in = 6'd0;
      if (fire) begin
         if (!shift_override_ff && scan == kms_pkg::SC_BAND_SHIFT) begin
            if (fire_kind == kms_pkg::EV_PRESS) begin
               band_in = ~band_ff;
            end
         end else if (!shift_override_ff && scan == kms_pkg::SC_ENC_SHIFT) begin
            if (fire_kind == kms_pkg::EV_PRESS) begin
               enc_in = ~enc_ff;
            end
         end else if (code != 6'd0) begin
            ev_valid_in = 1'b1;
            ev_kind_in = fire_kind;
            ev_code_in = code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_override_ff <= 1'b0;
         debounce_ticks_ff <= kms_pkg::DEBOUNCE_RESET;
         long_press_ticks_ff <= kms_pkg::LONG_PRESS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            kms_pkg::CSR_SHIFT_OVERRIDE: shift_override_ff <= csr_data[0];
            kms_pkg::CSR_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_data[7:0];
            kms_pkg::CSR_LONG_PRESS_TICKS: long_press_ticks_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= kms_pkg::PH_IDLE;
         column_ff <= '0;
         held_row_ff <= 4'd0;
         wait_ff <= 8'd0;
         hold_ff <= 16'd0;
         band_ff <= 1'b0;
         enc_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            phase_ff <= phase_in;
            column_ff <= column_in;
            held_row_ff <= held_row_in;
            wait_ff <= wait_in;
            hold_ff <= hold_in;
            band_ff <= band_in;
            enc_ff <= enc_in;
         end
         if (q_pop) begin
            out_valid_ff <= q_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         ev_valid_ff <= ev_valid_in;
         ev_kind_ff <= ev_kind_in;
         ev_code_ff <= ev_code_in;
         drive_ff <= 4'(4'b0001 << column_in);
         band_out_ff <= band_in;
         enc_out_ff <= enc_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_event_valid = ev_valid_ff;
   assign rsp_event_kind = ev_kind_ff;
   assign rsp_button_code = ev_code_ff;
   assign rsp_column_drive = drive_ff;
   assign rsp_band_shift_on = band_out_ff;
   assign rsp_encoder_shift_on = enc_out_ff;

endmodule
